// ----- hdl/square_wave_sound_channel_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the square-wave sound channel
// Shared concurrent assertion forms: same-cycle and next-cycle implication.
// ---------------------------------------------------------------------------
`ifndef SQUARE_WAVE_SOUND_CHANNEL_CORE_ASSERT_SVH
`define SQUARE_WAVE_SOUND_CHANNEL_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SQCH_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sqch assertion failed");

// antecedent implies consequent in the next cycle
`define SQCH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sqch assertion failed");

`endif

// ----- hdl/sqch_pkg.sv -----
// ---------------------------------------------------------------------------
// sqch_pkg
// Types, codes and tables of the square-wave sound channel.
// ---------------------------------------------------------------------------
package sqch_pkg;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_TIMER   = 2'd1,
    OP_QUARTER = 2'd2,
    OP_HALF    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_CTRL  = 2'd0,
    REG_SWEEP = 2'd1,
    REG_LO    = 2'd2,
    REG_HI    = 2'd3
  } reg_sel_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] reg_select;
    logic [7:0] write_data;
    logic       channel_enable;
  } in_item_t;

  typedef struct packed {
    logic [3:0] sample;
    logic       length_nonzero;
  } out_item_t;

  localparam logic [3:0]  VOL_MAX    = 4'd15;
  localparam logic [15:0] MIN_PERIOD = 16'd8;

  // bit n is the waveform level at duty step n
  localparam logic [7:0] DUTY_WAVE [4] = '{
    8'b0000_0010,
    8'b0000_0110,
    8'b0001_1110,
    8'b1111_1001
  };

  function automatic logic [7:0] length_lookup(input logic [4:0] idx);
    logic [7:0] val;
    case (idx)
      5'd0:  val = 8'd10;
      5'd1:  val = 8'd254;
      5'd2:  val = 8'd20;
      5'd3:  val = 8'd2;
      5'd4:  val = 8'd40;
      5'd5:  val = 8'd4;
      5'd6:  val = 8'd80;
      5'd7:  val = 8'd6;
      5'd8:  val = 8'd160;
      5'd9:  val = 8'd8;
      5'd10: val = 8'd60;
      5'd11: val = 8'd10;
      5'd12: val = 8'd14;
      5'd13: val = 8'd12;
      5'd14: val = 8'd26;
      5'd15: val = 8'd14;
      5'd16: val = 8'd12;
      5'd17: val = 8'd16;
      5'd18: val = 8'd24;
      5'd19: val = 8'd18;
      5'd20: val = 8'd48;
      5'd21: val = 8'd20;
      5'd22: val = 8'd96;
      5'd23: val = 8'd22;
      5'd24: val = 8'd192;
      5'd25: val = 8'd24;
      5'd26: val = 8'd72;
      5'd27: val = 8'd26;
      5'd28: val = 8'd16;
      5'd29: val = 8'd28;
      5'd30: val = 8'd32;
      default: val = 8'd30;
    endcase
    return val;
  endfunction

endpackage

// ----- hdl/sqch_in_reg.sv -----
// ---------------------------------------------------------------------------
// sqch_in_reg
// Input request register; holds one request until the channel takes it.
// ---------------------------------------------------------------------------
module sqch_in_reg import sqch_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     item_valid,
  input  logic     item_take,
  output in_item_t item
);

  logic     full;
  in_item_t data;

  assign in_ready   = !full || item_take;
  assign item_valid = full;
  assign item       = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_data;
    end
  end

endmodule

// ----- hdl/sqch_state.sv -----
// ---------------------------------------------------------------------------
// sqch_state
// Channel state: timer, duty sequencer, envelope, sweep, length counter.
// Applies a request per cycle while apply is high; forms the level after it.
// ---------------------------------------------------------------------------
module sqch_state import sqch_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      apply,
  input  in_item_t  item,
  input  logic      ones_comp,
  output out_item_t result
);

  logic [15:0] period_reg, period_reg_next;
  logic [15:0] timer_count, timer_count_next;
  logic [2:0]  duty_step, duty_step_next;
  logic [1:0]  duty_mode, duty_mode_next;
  logic        length_halt, length_halt_next;
  logic [7:0]  length_count, length_count_next;
  logic        constant_volume, constant_volume_next;
  logic [3:0]  envelope_period, envelope_period_next;
  logic        envelope_start, envelope_start_next;
  logic [3:0]  envelope_divider, envelope_divider_next;
  logic [3:0]  decay_level, decay_level_next;
  logic        sweep_enabled, sweep_enabled_next;
  logic [2:0]  sweep_period, sweep_period_next;
  logic        sweep_negate, sweep_negate_next;
  logic [2:0]  sweep_shift, sweep_shift_next;
  logic        sweep_reload, sweep_reload_next;
  logic [2:0]  sweep_divider, sweep_divider_next;

  logic [15:0] delta;
  logic [15:0] swept;
  logic [3:0]  volume;
  logic        audible;

  assign delta = period_reg >> sweep_shift;
  assign swept = sweep_negate ? (period_reg - delta - {15'd0, ones_comp})
                              : (period_reg + delta);

  always_comb begin
    period_reg_next       = period_reg;
    timer_count_next      = timer_count;
    duty_step_next        = duty_step;
    duty_mode_next        = duty_mode;
    length_halt_next      = length_halt;
    length_count_next     = length_count;
    constant_volume_next  = constant_volume;
    envelope_period_next  = envelope_period;
    envelope_start_next   = envelope_start;
    envelope_divider_next = envelope_divider;
    decay_level_next      = decay_level;
    sweep_enabled_next    = sweep_enabled;
    sweep_period_next     = sweep_period;
    sweep_negate_next     = sweep_negate;
    sweep_shift_next      = sweep_shift;
    sweep_reload_next     = sweep_reload;
    sweep_divider_next    = sweep_divider;
    unique case (item.opcode)
      OP_WRITE: begin
        unique case (item.reg_select)
          REG_CTRL: begin
            duty_mode_next       = item.write_data[7:6];
            length_halt_next     = item.write_data[5];
            constant_volume_next = item.write_data[4];
            envelope_period_next = item.write_data[3:0];
          end
          REG_SWEEP: begin
            sweep_enabled_next = item.write_data[7];
            sweep_period_next  = item.write_data[6:4];
            sweep_negate_next  = item.write_data[3];
            sweep_shift_next   = item.write_data[2:0];
            sweep_reload_next  = 1'b1;
          end
          REG_LO: begin
            period_reg_next = {period_reg[15:8], item.write_data};
          end
          default: begin
            period_reg_next = {5'd0, item.write_data[2:0], period_reg[7:0]};
            if (item.channel_enable) begin
              length_count_next = length_lookup(item.write_data[7:3]);
            end
            duty_step_next      = 3'd0;
            envelope_start_next = 1'b1;
          end
        endcase
      end
      OP_TIMER: begin
        if (timer_count == 16'd0) begin
          timer_count_next = period_reg;
          duty_step_next   = duty_step + 3'd1;
        end else begin
          timer_count_next = timer_count - 16'd1;
        end
      end
      OP_QUARTER: begin
        if (envelope_start) begin
          envelope_start_next   = 1'b0;
          decay_level_next      = VOL_MAX;
          envelope_divider_next = envelope_period;
        end else if (envelope_divider == 4'd0) begin
          envelope_divider_next = envelope_period;
          if (decay_level != 4'd0) begin
            decay_level_next = decay_level - 4'd1;
          end else if (length_halt) begin
            decay_level_next = VOL_MAX;
          end
        end else begin
          envelope_divider_next = envelope_divider - 4'd1;
        end
      end
      default: begin
        if (!length_halt && length_count != 8'd0) begin
          length_count_next = length_count - 8'd1;
        end
        if (sweep_reload) begin
          sweep_divider_next = sweep_period;
          sweep_reload_next  = 1'b0;
        end else if (sweep_divider == 3'd0) begin
          sweep_divider_next = sweep_period;
          if (sweep_enabled && sweep_shift != 3'd0) begin
            period_reg_next = swept;
          end
        end else begin
          sweep_divider_next = sweep_divider - 3'd1;
        end
      end
    endcase
  end

  always_comb begin
    volume  = constant_volume_next ? envelope_period_next : decay_level_next;
    audible = (length_count_next != 8'd0) && (period_reg_next >= MIN_PERIOD) &&
              DUTY_WAVE[duty_mode_next][duty_step_next];
    result.sample         = audible ? volume : 4'd0;
    result.length_nonzero = (length_count_next != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_reg       <= '0;
      timer_count      <= '0;
      duty_step        <= '0;
      duty_mode        <= '0;
      length_halt      <= 1'b0;
      length_count     <= '0;
      constant_volume  <= 1'b0;
      envelope_period  <= '0;
      envelope_start   <= 1'b0;
      envelope_divider <= '0;
      decay_level      <= '0;
      sweep_enabled    <= 1'b0;
      sweep_period     <= '0;
      sweep_negate     <= 1'b0;
      sweep_shift      <= '0;
      sweep_reload     <= 1'b0;
      sweep_divider    <= '0;
    end else if (apply) begin
      period_reg       <= period_reg_next;
      timer_count      <= timer_count_next;
      duty_step        <= duty_step_next;
      duty_mode        <= duty_mode_next;
      length_halt      <= length_halt_next;
      length_count     <= length_count_next;
      constant_volume  <= constant_volume_next;
      envelope_period  <= envelope_period_next;
      envelope_start   <= envelope_start_next;
      envelope_divider <= envelope_divider_next;
      decay_level      <= decay_level_next;
      sweep_enabled    <= sweep_enabled_next;
      sweep_period     <= sweep_period_next;
      sweep_negate     <= sweep_negate_next;
      sweep_shift      <= sweep_shift_next;
      sweep_reload     <= sweep_reload_next;
      sweep_divider    <= sweep_divider_next;
    end
  end

endmodule

// ----- hdl/sqch_out_reg.sv -----
// ---------------------------------------------------------------------------
// sqch_out_reg
// Result register; holds a result until the receiver takes it.
// ---------------------------------------------------------------------------
module sqch_out_reg import sqch_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  output logic      can_load,
  input  out_item_t result,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      full;
  out_item_t data;

  assign can_load  = !full || out_ready;
  assign out_valid = full;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (can_load) begin
      full <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

endmodule

// ----- hdl/square_wave_sound_channel_core.sv -----
// ---------------------------------------------------------------------------
// square_wave_sound_channel_core
// Square-wave sound channel: each request is a register write, a timer
// tick, a quarter-frame tick (envelope) or a half-frame tick (length and
// sweep); each request returns one result, the level after it and the
// length-counter status.
// Channels: in_valid/in_ready/in_data request, out_valid/out_ready/out_data
// result, cfg_wr_en/cfg_wr_data for the sweep negate mode bit.
// Path: an accepted request waits in the input register; once the result
// register can load, the state update and the result load happen
// together, and the result shows on out_data after that load.
// Throughput: one request per cycle while out_ready stays high.
// Stall: with out_ready low the result holds, one more request waits in the
// input register, then in_ready drops.
// Reset: all channel state and the negate mode bit clear, both registers
// empty.
// ---------------------------------------------------------------------------
module square_wave_sound_channel_core import sqch_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  logic      item_valid;
  logic      can_load;
  logic      advance;
  in_item_t  item;
  out_item_t result;
  logic      ones_comp;

  assign advance = item_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      ones_comp <= 1'b0;
    end else if (cfg_wr_en) begin
      ones_comp <= cfg_wr_data;
    end
  end

  sqch_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item_take  (advance),
    .item       (item)
  );

  sqch_state u_state (
    .clk       (clk),
    .rst       (rst),
    .apply     (advance),
    .item      (item),
    .ones_comp (ones_comp),
    .result    (result)
  );

  sqch_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .can_load  (can_load),
    .result    (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/sqch_checker.sv -----
// ---------------------------------------------------------------------------
// sqch_checker
// Port-level checks for the square-wave sound channel, bound to the top.
// ---------------------------------------------------------------------------
`include "square_wave_sound_channel_core_assert.svh"

module sqch_checker import sqch_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // result stays valid while stalled
  `SQCH_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // no sound once the length counter has run out
  `SQCH_ASSERT_NOW(a_len_silence, clk, rst, out_valid && !out_data.length_nonzero,
    out_data.sample == 4'd0)

  // backpressure only comes from a stalled result
  `SQCH_ASSERT_NOW(a_ready_cause, clk, rst, !in_ready, out_valid && !out_ready)

  // nothing shown right after reset
  `SQCH_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !out_valid)

endmodule

bind square_wave_sound_channel_core sqch_checker u_sqch_checker (.*);

// ----- tb/sqch_level_checker.sv -----
// ---------------------------------------------------------------------------
// sqch_level_checker
// Watches the request and result channels of the square-wave sound channel,
// runs its own copy of the channel state for every accepted request and
// compares each result, field by field, with the oldest predicted level.
// ---------------------------------------------------------------------------
module sqch_level_checker import sqch_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  output int        failures,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] LEN_LOAD [32] = '{
    8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
    8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };

  // bit n: waveform high at step n
  localparam logic [7:0] PULSE_SHAPE [4] = '{
    8'b0000_0010, 8'b0000_0110, 8'b0001_1110, 8'b1111_1001
  };

  logic        neg_minus_one;
  logic [15:0] tone_period;
  logic [15:0] tone_timer;
  logic [2:0]  wave_pos;
  logic [1:0]  wave_shape;
  logic        len_hold;
  logic [7:0]  len_left;
  logic        fixed_vol;
  logic [3:0]  env_rate;
  logic        env_restart;
  logic [3:0]  env_div;
  logic [3:0]  env_level;
  logic        swp_on;
  logic [2:0]  swp_rate;
  logic        swp_down;
  logic [2:0]  swp_amount;
  logic        swp_restart;
  logic [2:0]  swp_div;

  out_item_t levels_due[$];

  task automatic clear_channel();
    neg_minus_one = 1'b0;
    tone_period   = '0;
    tone_timer    = '0;
    wave_pos      = '0;
    wave_shape    = '0;
    len_hold      = 1'b0;
    len_left      = '0;
    fixed_vol     = 1'b0;
    env_rate      = '0;
    env_restart   = 1'b0;
    env_div       = '0;
    env_level     = '0;
    swp_on        = 1'b0;
    swp_rate      = '0;
    swp_down      = 1'b0;
    swp_amount    = '0;
    swp_restart   = 1'b0;
    swp_div       = '0;
  endtask

  task automatic apply_request(input in_item_t req, output out_item_t res);
    logic [15:0] delta;
    case (req.opcode)
      OP_WRITE: begin
        case (req.reg_select)
          REG_CTRL: begin
            wave_shape = req.write_data[7:6];
            len_hold   = req.write_data[5];
            fixed_vol  = req.write_data[4];
            env_rate   = req.write_data[3:0];
          end
          REG_SWEEP: begin
            swp_on      = req.write_data[7];
            swp_rate    = req.write_data[6:4];
            swp_down    = req.write_data[3];
            swp_amount  = req.write_data[2:0];
            swp_restart = 1'b1;
          end
          REG_LO: begin
            tone_period[7:0] = req.write_data;
          end
          default: begin
            tone_period[15:8] = {5'd0, req.write_data[2:0]};
            if (req.channel_enable)
              len_left = LEN_LOAD[req.write_data[7:3]];
            wave_pos    = '0;
            env_restart = 1'b1;
          end
        endcase
      end
      OP_TIMER: begin
        if (tone_timer == 16'd0) begin
          tone_timer = tone_period;
          wave_pos   = wave_pos + 3'd1;
        end else begin
          tone_timer = tone_timer - 16'd1;
        end
      end
      OP_QUARTER: begin
        if (env_restart) begin
          env_restart = 1'b0;
          env_level   = 4'd15;
          env_div     = env_rate;
        end else if (env_div == 4'd0) begin
          env_div = env_rate;
          if (env_level != 4'd0)
            env_level = env_level - 4'd1;
          else if (len_hold)
            env_level = 4'd15;
        end else begin
          env_div = env_div - 4'd1;
        end
      end
      default: begin
        if (!len_hold && len_left != 8'd0)
          len_left = len_left - 8'd1;
        if (swp_restart) begin
          swp_div     = swp_rate;
          swp_restart = 1'b0;
        end else if (swp_div == 3'd0) begin
          swp_div = swp_rate;
          if (swp_on && swp_amount != 3'd0) begin
            delta = tone_period >> swp_amount;
            if (swp_down)
              tone_period = tone_period - delta - {15'd0, neg_minus_one};
            else
              tone_period = tone_period + delta;
          end
        end else begin
          swp_div = swp_div - 3'd1;
        end
      end
    endcase
    res.length_nonzero = (len_left != 8'd0);
    if (len_left == 8'd0 || tone_period < 16'd8 || !PULSE_SHAPE[wave_shape][wave_pos])
      res.sample = 4'd0;
    else
      res.sample = fixed_vol ? env_rate : env_level;
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t due;
    if (rst) begin
      clear_channel();
      levels_due.delete();
      failures = 0;
    end else begin
      if (cfg_wr_en)
        neg_minus_one = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (levels_due.size() == 0) begin
          $error("result with no request outstanding: sample %0d length_nonzero %0d",
                 out_data.sample, out_data.length_nonzero);
          failures++;
        end else begin
          due = levels_due.pop_front();
          if (out_data.sample !== due.sample) begin
            $error("sample: expected %0d, got %0d", due.sample, out_data.sample);
            failures++;
          end
          if (out_data.length_nonzero !== due.length_nonzero) begin
            $error("length_nonzero: expected %0d, got %0d",
                   due.length_nonzero, out_data.length_nonzero);
            failures++;
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_request(in_data, want);
        levels_due.push_back(want);
      end
    end
    pending = levels_due.size();
  end

endmodule

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Drives the square-wave sound channel with a directed set of register
// writes and ticks, then three random request streams with negate mode
// one, zero, one, bursty requests and a stalling result side; the checker
// predicts every level and reports mismatches.
// ---------------------------------------------------------------------------
module testbench;
  import sqch_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT_NS = 2_000_000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_wr_en;
  logic      cfg_wr_data;
  int        failures;
  int        pending;

  square_wave_sound_channel_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  sqch_level_checker level_chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .failures    (failures),
    .pending     (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic in_item_t mk(input logic [1:0] op, input logic [1:0] sel,
                                  input logic [7:0] data, input logic en);
    in_item_t r;
    r.opcode         = op;
    r.reg_select     = sel;
    r.write_data     = data;
    r.channel_enable = en;
    return r;
  endfunction

  function automatic in_item_t random_request();
    in_item_t r;
    int pick;
    pick             = $urandom_range(0, 99);
    r.reg_select     = 2'($urandom);
    r.write_data     = 8'($urandom);
    r.channel_enable = ($urandom_range(0, 3) != 0);
    if (pick < 40)
      r.opcode = OP_TIMER;
    else if (pick < 58)
      r.opcode = OP_QUARTER;
    else if (pick < 76)
      r.opcode = OP_HALF;
    else
      r.opcode = OP_WRITE;
    // keep periods short often enough that the duty step moves
    if (r.opcode == OP_WRITE && r.reg_select == REG_LO && $urandom_range(0, 1) == 1)
      r.write_data = 8'($urandom_range(0, 40));
    if (r.opcode == OP_WRITE && r.reg_select == REG_HI && $urandom_range(0, 1) == 1)
      r.write_data[2:0] = 3'd0;
    return r;
  endfunction

  task automatic offer(input in_item_t r);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_negate_mode(input logic v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_random(input int total);
    int sent;
    int burst;
    sent = 0;
    while (sent < total) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < total; k++) begin
        offer(random_request());
        sent++;
      end
      if ($urandom_range(0, 3) != 0)
        pause_sender($urandom_range(1, 6));
    end
  endtask

  // result side: random stall patterns, plus one long hold-off to back up the input
  initial begin
    int cyc;
    int seg;
    int mode;
    out_ready = 1'b0;
    cyc = 0;
    forever begin
      seg  = $urandom_range(16, 120);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        @(negedge clk);
        cyc++;
        if (cyc == 700) begin
          repeat (300) begin
            out_ready <= 1'b0;
            @(negedge clk);
          end
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_negate_mode(1'b0);

    offer(mk(OP_TIMER,   REG_CTRL,  8'h00, 1'b0));
    offer(mk(OP_WRITE,   REG_HI,    8'hFF, 1'b0));  // length stays zero
    offer(mk(OP_WRITE,   REG_LO,    8'hFF, 1'b0));
    offer(mk(OP_WRITE,   REG_HI,    8'h07, 1'b1));
    offer(mk(OP_WRITE,   REG_CTRL,  8'hDF, 1'b0));
    offer(mk(OP_WRITE,   REG_SWEEP, 8'h99, 1'b0));
    offer(mk(OP_HALF,    REG_CTRL,  8'h00, 1'b0));
    offer(mk(OP_HALF,    REG_CTRL,  8'h00, 1'b0));
    offer(mk(OP_HALF,    REG_CTRL,  8'h00, 1'b0));
    offer(mk(OP_QUARTER, REG_CTRL,  8'h00, 1'b0));
    offer(mk(OP_QUARTER, REG_CTRL,  8'h00, 1'b0));
    offer(mk(OP_WRITE,   REG_SWEEP, 8'h88, 1'b0));  // zero shift
    offer(mk(OP_HALF,    REG_CTRL,  8'h00, 1'b0));
    offer(mk(OP_HALF,    REG_CTRL,  8'h00, 1'b0));
    offer(mk(OP_WRITE,   REG_SWEEP, 8'h87, 1'b0));
    offer(mk(OP_HALF,    REG_CTRL,  8'h00, 1'b0));
    offer(mk(OP_HALF,    REG_CTRL,  8'h00, 1'b0));
    offer(mk(OP_WRITE,   REG_HI,    8'hF8, 1'b1));
    offer(mk(OP_WRITE,   REG_LO,    8'h00, 1'b0));  // period below eight
    offer(mk(OP_WRITE,   REG_LO,    8'h09, 1'b0));
    offer(mk(OP_WRITE,   REG_CTRL,  8'h20, 1'b0));
    offer(mk(OP_WRITE,   REG_HI,    8'h08, 1'b1));
    offer(mk(OP_QUARTER, REG_CTRL,  8'h00, 1'b0));
    offer(mk(OP_TIMER,   REG_HI,    8'hFF, 1'b1));  // write fields ignored
    offer(mk(OP_TIMER,   REG_CTRL,  8'h00, 1'b0));
    drain();

    set_negate_mode(1'b1);
    run_random(460);
    drain();
    set_negate_mode(1'b0);
    run_random(460);
    drain();
    set_negate_mode(1'b1);
    run_random(480);
    drain();

    if (failures == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

// ----- square_wave_sound_channel_core.f -----
+incdir+hdl
hdl/sqch_pkg.sv
hdl/sqch_in_reg.sv
hdl/sqch_state.sv
hdl/sqch_out_reg.sv
hdl/square_wave_sound_channel_core.sv
hdl/sqch_checker.sv
tb/sqch_level_checker.sv
tb/testbench.sv
